// File: rtl/tea_pkg.sv
package tea_pkg;

   localparam int MAX_EDGES     = 4096;
   localparam int VERTEX_BITS   = 16;
   localparam int NUM_CELLS     = 16;
   localparam int SLOT_BITS     = $clog2(MAX_EDGES);
   localparam int COUNT_BITS    = SLOT_BITS + 1;
   localparam int LANE_BITS     = $clog2(NUM_CELLS);
   localparam int ROW_BITS      = SLOT_BITS - LANE_BITS;
   localparam int ROWS_PER_CELL = MAX_EDGES / NUM_CELLS;
   // two register stages per cell plus margin for the tail capture
   localparam int DRAIN_CYCLES  = 2 * NUM_CELLS + 2;
   localparam int DRAIN_BITS    = $clog2(DRAIN_CYCLES + 1);

   typedef logic [VERTEX_BITS-1:0] vertex_type;
   typedef logic [SLOT_BITS-1:0]   slot_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [ROW_BITS-1:0]    row_type;
   typedef logic [LANE_BITS-1:0]   lane_type;
   typedef logic [ROW_BITS:0]      issue_type;
   typedef logic [DRAIN_BITS-1:0]  drain_type;

   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_CLEAR = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_EXISTING = 2'd0,
      STATUS_ADDED    = 2'd1,
      STATUS_DROPPED  = 2'd2,
      STATUS_CLEARED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EDGE_AB = 2'd0,
      EDGE_AC = 2'd1,
      EDGE_CB = 2'd2
   } edge_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_APPLY,
      ST_SEND
   } state_type;

   typedef struct packed {
      vertex_type lo;
      vertex_type hi;
      vertex_type near_first;
      vertex_type near_second;
   } entry_type;

   typedef struct packed {
      vertex_type lo;
      vertex_type hi;
   } key_type;

   typedef struct packed {
      logic       valid;
      row_type    row;
      logic       found;
      slot_type   slot;
      vertex_type near_first;
      vertex_type near_second;
   } token_type;

   typedef struct packed {
      logic      en;
      row_type   row;
      lane_type  lane;
      entry_type data;
   } write_type;

endpackage

// File: rtl/tea_if.sv
interface tea_req_if import tea_pkg::*; ();
   logic        valid;
   logic        ready;
   command_type command;
   vertex_type  vertex_a;
   vertex_type  vertex_b;
   vertex_type  vertex_c;

   modport source (output valid, output command, output vertex_a, output vertex_b,
                   output vertex_c, input ready);
   modport sink   (input valid, input command, input vertex_a, input vertex_b,
                   input vertex_c, output ready);
endinterface

interface tea_rsp_if import tea_pkg::*; ();
   logic       valid;
   logic       ready;
   slot_type   edge_slot;
   vertex_type edge_low;
   vertex_type edge_high;
   vertex_type near_first;
   vertex_type near_second;
   status_type status;
   logic       last;

   modport source (output valid, output edge_slot, output edge_low, output edge_high,
                   output near_first, output near_second, output status, output last,
                   input ready);
   modport sink   (input valid, input edge_slot, input edge_low, input edge_high,
                   input near_first, input near_second, input status, input last,
                   output ready);
endinterface

// File: rtl/tea_ram.sv
module tea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tea_cell.sv
module tea_cell import tea_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  lane_type   cell_lane,
   input  key_type    key,
   input  count_type  edge_count,
   input  token_type  tok_in,
   input  write_type  wr,
   output token_type  tok_out
);

   token_type hold_ff, hold_in;
   token_type out_ff, out_in;
   entry_type rd_data;
   slot_type  slot;
   logic      in_range;
   logic      match;

   // this cell owns slots whose low bits equal its lane
   tea_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ROWS_PER_CELL)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en && (wr.lane == cell_lane)),
      .wr_addr (wr.row),
      .wr_data (wr.data),
      .rd_addr (tok_in.row),
      .rd_data (rd_data)
   );

   assign hold_in = tok_in;

   always_comb begin
      slot     = {hold_ff.row, cell_lane};
      in_range = {1'b0, slot} < edge_count;
      match    = (rd_data.lo == key.lo) && (rd_data.hi == key.hi);
      out_in   = hold_ff;
      // earlier cells and rows hold lower slots, so the first claim wins
      if (hold_ff.valid && !hold_ff.found && in_range && match) begin
         out_in.found       = 1'b1;
         out_in.slot        = slot;
         out_in.near_first  = rd_data.near_first;
         out_in.near_second = rd_data.near_second;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      out_ff  <= out_in;
      if (reset) begin
         hold_ff.valid <= 1'b0;
         out_ff.valid  <= 1'b0;
      end
   end

   assign tok_out = out_ff;

endmodule

// File: rtl/triangle_edge_adjacency_table_core.sv
// channel   dir  transaction
// req_chan  in   command, vertex_a, vertex_b, vertex_c
// rsp_chan  out  edge_slot, edge_low, edge_high, near_first, near_second, status, last
//
// a clear is accepted, then sends its single response
// an add is accepted, then per edge a token per row of 16 slots walks the 16-cell chain,
// two stages a cell, then drain, apply and send
// edges are handled one after another, each sees the writes of the one before
// reset empties the table at once; table contents are undefined until written
// req_chan stalls for the whole item; a stalled response holds its payload and adds cycles
module triangle_edge_adjacency_table_core import tea_pkg::*; (
   input logic        clock,
   input logic        reset,
   tea_req_if.sink    req_chan,
   tea_rsp_if.source  rsp_chan
);

   state_type    state_ff, state_in;
   count_type    edge_count_ff;
   vertex_type   vert_a_ff, vert_b_ff, vert_c_ff;
   edge_sel_type edge_sel_ff, edge_sel_next;
   issue_type    issue_ff;
   issue_type    rows_needed;
   count_type    rows_sum;
   drain_type    drain_ff;
   token_type    tok0_ff;
   logic         hit_found_ff;
   slot_type     hit_slot_ff;
   vertex_type   hit_near_first_ff, hit_near_second_ff;

   slot_type     rsp_slot_ff, rsp_slot_in;
   vertex_type   rsp_low_ff, rsp_high_ff;
   vertex_type   rsp_near_first_ff, rsp_near_first_in;
   vertex_type   rsp_near_second_ff, rsp_near_second_in;
   status_type   rsp_status_ff, rsp_status_in;
   logic         rsp_last_ff;
   logic         rsp_valid_ff;

   vertex_type   p, q, opp;
   key_type      key;
   logic         issue_more;
   logic         req_accept, rsp_accept;
   logic         req_ready, inject, do_apply, count_inc;
   write_type    wr;
   token_type    chain [NUM_CELLS+1];

   // ---------------------------------------------------------------- edge select
   always_comb begin
      case (edge_sel_ff)
         EDGE_AB: begin
            p = vert_a_ff; q = vert_b_ff; opp = vert_c_ff;
         end
         EDGE_AC: begin
            p = vert_a_ff; q = vert_c_ff; opp = vert_b_ff;
         end
         default: begin
            p = vert_c_ff; q = vert_b_ff; opp = vert_a_ff;
         end
      endcase
      key.lo = (p < q) ? p : q;
      key.hi = (p < q) ? q : p;
   end

   always_comb begin
      case (edge_sel_ff)
         EDGE_AB: edge_sel_next = EDGE_AC;
         EDGE_AC: edge_sel_next = EDGE_CB;
         default: edge_sel_next = EDGE_AB;
      endcase
   end

   assign rows_sum    = edge_count_ff + count_type'(NUM_CELLS - 1);
   assign rows_needed = rows_sum[COUNT_BITS-1:LANE_BITS];
   assign issue_more  = issue_ff < rows_needed;

   assign req_accept = req_chan.valid && req_ready;
   assign rsp_accept = rsp_valid_ff && rsp_chan.ready;

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_chan.command == CMD_CLEAR) ? ST_SEND : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!issue_more) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_accept) begin
               state_in = rsp_last_ff ? ST_IDLE : ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      inject    = 1'b0;
      do_apply  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SCAN:  inject    = issue_more;
         ST_APPLY: do_apply  = 1'b1;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- table update
   always_comb begin
      wr                 = '0;
      count_inc          = 1'b0;
      rsp_slot_in        = '0;
      rsp_near_first_in  = '0;
      rsp_near_second_in = '0;
      rsp_status_in      = STATUS_DROPPED;
      if (hit_found_ff) begin
         rsp_slot_in        = hit_slot_ff;
         rsp_near_first_in  = hit_near_first_ff;
         rsp_status_in      = STATUS_EXISTING;
         // only an edge seen once so far takes a second neighbour
         if (hit_near_first_ff == hit_near_second_ff) begin
            rsp_near_second_in = opp;
            wr.en              = do_apply;
         end else begin
            rsp_near_second_in = hit_near_second_ff;
         end
         wr.row  = hit_slot_ff[SLOT_BITS-1:LANE_BITS];
         wr.lane = hit_slot_ff[LANE_BITS-1:0];
         wr.data = '{lo: key.lo, hi: key.hi, near_first: hit_near_first_ff,
                     near_second: opp};
      end else if (edge_count_ff != count_type'(MAX_EDGES)) begin
         rsp_slot_in        = edge_count_ff[SLOT_BITS-1:0];
         rsp_near_first_in  = opp;
         rsp_near_second_in = opp;
         rsp_status_in      = STATUS_ADDED;
         count_inc          = do_apply;
         wr.en              = do_apply;
         wr.row             = edge_count_ff[SLOT_BITS-1:LANE_BITS];
         wr.lane            = edge_count_ff[LANE_BITS-1:0];
         wr.data            = '{lo: key.lo, hi: key.hi, near_first: opp, near_second: opp};
      end
   end

   // ---------------------------------------------------------------- search chain
   assign chain[0] = tok0_ff;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      tea_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_lane  (lane_type'(i)),
         .key        (key),
         .edge_count (edge_count_ff),
         .tok_in     (chain[i]),
         .wr         (wr),
         .tok_out    (chain[i+1])
      );
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      state_ff <= state_in;

      tok0_ff.valid       <= inject;
      tok0_ff.row         <= issue_ff[ROW_BITS-1:0];
      tok0_ff.found       <= 1'b0;
      tok0_ff.slot        <= '0;
      tok0_ff.near_first  <= '0;
      tok0_ff.near_second <= '0;
      if (inject) begin
         issue_ff <= issue_ff + issue_type'(1);
      end

      if (state_ff == ST_SCAN) begin
         drain_ff <= drain_type'(DRAIN_CYCLES);
      end else if (state_ff == ST_DRAIN) begin
         drain_ff <= drain_ff - drain_type'(1);
      end

      // keep the first hit out of the chain: it has the lowest slot
      if (chain[NUM_CELLS].valid && chain[NUM_CELLS].found && !hit_found_ff) begin
         hit_found_ff       <= 1'b1;
         hit_slot_ff        <= chain[NUM_CELLS].slot;
         hit_near_first_ff  <= chain[NUM_CELLS].near_first;
         hit_near_second_ff <= chain[NUM_CELLS].near_second;
      end

      if (count_inc) begin
         edge_count_ff <= edge_count_ff + count_type'(1);
      end

      if (do_apply) begin
         rsp_valid_ff       <= 1'b1;
         rsp_slot_ff        <= rsp_slot_in;
         rsp_low_ff         <= key.lo;
         rsp_high_ff        <= key.hi;
         rsp_near_first_ff  <= rsp_near_first_in;
         rsp_near_second_ff <= rsp_near_second_in;
         rsp_status_ff      <= rsp_status_in;
         rsp_last_ff        <= (edge_sel_ff == EDGE_CB);
      end

      if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
         if (!rsp_last_ff) begin
            edge_sel_ff  <= edge_sel_next;
            issue_ff     <= '0;
            hit_found_ff <= 1'b0;
         end
      end

      if (req_accept) begin
         vert_a_ff    <= req_chan.vertex_a;
         vert_b_ff    <= req_chan.vertex_b;
         vert_c_ff    <= req_chan.vertex_c;
         edge_sel_ff  <= EDGE_AB;
         issue_ff     <= '0;
         hit_found_ff <= 1'b0;
         if (req_chan.command == CMD_CLEAR) begin
            edge_count_ff      <= '0;
            rsp_valid_ff       <= 1'b1;
            rsp_slot_ff        <= '0;
            rsp_low_ff         <= '0;
            rsp_high_ff        <= '0;
            rsp_near_first_ff  <= '0;
            rsp_near_second_ff <= '0;
            rsp_status_ff      <= STATUS_CLEARED;
            rsp_last_ff        <= 1'b1;
         end
      end

      if (reset) begin
         state_ff      <= ST_IDLE;
         edge_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         tok0_ff.valid <= 1'b0;
         hit_found_ff  <= 1'b0;
         issue_ff      <= '0;
         drain_ff      <= '0;
         edge_sel_ff   <= EDGE_AB;
      end
   end

   // ---------------------------------------------------------------- ports
   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.edge_slot   = rsp_slot_ff;
   assign rsp_chan.edge_low    = rsp_low_ff;
   assign rsp_chan.edge_high   = rsp_high_ff;
   assign rsp_chan.near_first  = rsp_near_first_ff;
   assign rsp_chan.near_second = rsp_near_second_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule
